// ===== sv/rrc_pkg.sv =====
// Shared types, constants and codes of the rectangle raster canvas.
package rrc_pkg;

  localparam int MAX_COLUMNS   = 256;
  localparam int MAX_ROWS      = 256;
  localparam int FRACTION_BITS = 8;

  localparam int FIELD_W = 21;  // width of a fixed point input field
  localparam int DIM_W   = 9;   // width of the dimension registers
  localparam int CHAR_W  = 8;
  localparam int PIX_W   = 8;   // width of the read coordinates

  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int IDX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = 1 << ADDR_W;

  // Room for sums of two fields and for a pixel index scaled to fixed point.
  localparam int COORD_W = (IDX_W + FRACTION_BITS + 2 > FIELD_W + 2) ?
                           IDX_W + FRACTION_BITS + 2 : FIELD_W + 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t ONE = coord_t'(64'd1 << FRACTION_BITS);

  localparam logic [DIM_W-1:0]  RST_WIDTH  = DIM_W'(256);
  localparam logic [DIM_W-1:0]  RST_HEIGHT = DIM_W'(256);
  localparam logic [CHAR_W-1:0] RST_BG     = CHAR_W'(32);

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BG     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_PREP2,
    S_SWEEP,
    S_READ,
    S_READ_WAIT,
    S_DONE
  } state_e;

  // Rectangle edges and the edges moved inward by one unit.
  typedef struct packed {
    coord_t lx;
    coord_t lx1;
    coord_t rx;
    coord_t rx1;
    coord_t ty;
    coord_t ty1;
    coord_t by;
    coord_t by1;
  } rect_bounds_t;

  typedef struct packed {
    logic hit;
    logic border;
  } pix_class_t;

endpackage

// ===== sv/rrc_ram.sv =====
// Generic single-port RAM with registered read.
module rrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/rrc_hit.sv =====
// Per-pixel compare unit: classes one pixel against the rectangle.
module rrc_hit (
  input  rrc_pkg::coord_t       px_i,
  input  rrc_pkg::coord_t       py_i,
  input  rrc_pkg::rect_bounds_t bounds_i,
  output rrc_pkg::pix_class_t   class_o
);

  rrc_pkg::coord_t lx, lx1, rx, rx1, ty, ty1, by, by1;

  assign lx  = bounds_i.lx;
  assign lx1 = bounds_i.lx1;
  assign rx  = bounds_i.rx;
  assign rx1 = bounds_i.rx1;
  assign ty  = bounds_i.ty;
  assign ty1 = bounds_i.ty1;
  assign by  = bounds_i.by;
  assign by1 = bounds_i.by1;

  // Border: less than one unit from an edge, i.e. px < lx+1 or px > rx-1.
  assign class_o.hit    = (px_i >= lx) && (px_i <= rx) && (py_i >= ty) && (py_i <= by);
  assign class_o.border = (px_i < lx1) || (px_i > rx1) || (py_i < ty1) || (py_i > by1);

endmodule

// ===== sv/rectangle_raster_canvas.sv =====
// Top level of the rectangle raster canvas: sequencer, canvas RAM, result register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  in       | in_valid_i/in_stall_o| req_type, rect_*, filled, paint_char, pixel_x/y
//  out      | out_valid_o/out_stall_i | status, pixel_char
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Clear sweeps every canvas pixel; draw first passes the setup states S_PREP and S_PREP2,
//  then sweeps, one canvas pixel per cycle through the single RAM port; read passes S_READ and S_READ_WAIT.
//  A size error, an unused request, a clear of an empty canvas or an out-of-range read
//  goes straight to S_DONE; a draw on an empty canvas still passes S_PREP and S_PREP2.
//  rst_ni resets control and sets configuration to its defaults; canvas contents stay undefined until a clear.
//  in_stall_o stays high from acceptance until the result is loaded into the output
//  register; a stalled result holds the engine in its final state until it can load.
module rectangle_raster_canvas (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          req_type_i,
  input  logic signed [rrc_pkg::FIELD_W-1:0]  rect_left_x_i,
  input  logic signed [rrc_pkg::FIELD_W-1:0]  rect_top_y_i,
  input  logic signed [rrc_pkg::FIELD_W-1:0]  rect_width_i,
  input  logic signed [rrc_pkg::FIELD_W-1:0]  rect_height_i,
  input  logic                                filled_i,
  input  logic [rrc_pkg::CHAR_W-1:0]          paint_char_i,
  input  logic [rrc_pkg::PIX_W-1:0]           pixel_x_i,
  input  logic [rrc_pkg::PIX_W-1:0]           pixel_y_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [rrc_pkg::CHAR_W-1:0]          pixel_char_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [rrc_pkg::DIM_W-1:0]           cfg_data_i
);

  // Configuration registers
  logic [rrc_pkg::DIM_W-1:0]  canvas_width_q, canvas_height_q;
  logic [rrc_pkg::CHAR_W-1:0] background_char_q;

  // Sequencer state
  rrc_pkg::state_e state_q, state_d;

  // Captured item
  rrc_pkg::req_e              req_q;
  logic                       filled_q;
  logic [rrc_pkg::CHAR_W-1:0] paint_q;
  rrc_pkg::coord_t            lx_q, ty_q, w_q, h_q;
  rrc_pkg::rect_bounds_t      bounds_q;
  logic [rrc_pkg::COL_W-1:0]  rd_x_q;
  logic [rrc_pkg::ROW_W-1:0]  rd_y_q;

  // Sweep counters
  logic [rrc_pkg::COL_W-1:0]  x_q;
  logic [rrc_pkg::ROW_W-1:0]  y_q;

  // Result before the output register, and the output register itself
  rrc_pkg::status_e           res_status_q;
  logic [rrc_pkg::CHAR_W-1:0] res_pix_q;
  logic                       out_valid_q;
  logic [1:0]                 out_status_q;
  logic [rrc_pkg::CHAR_W-1:0] out_pix_q;

  // Combinational
  logic [rrc_pkg::DIM_W-1:0]  cols, rows;
  logic                       in_accept, canvas_empty, size_bad, read_out;
  logic                       last_x, last_y, out_free;
  rrc_pkg::req_e              in_req;
  rrc_pkg::coord_t            px, py;
  rrc_pkg::pix_class_t        pix_class;
  logic                       ram_we;
  logic [rrc_pkg::ADDR_W-1:0] ram_addr;
  logic [rrc_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;

  // Saturate the dimensions to the canvas storage
  assign cols = (32'(canvas_width_q) > 32'(rrc_pkg::MAX_COLUMNS)) ?
                rrc_pkg::DIM_W'(rrc_pkg::MAX_COLUMNS) : canvas_width_q;
  assign rows = (32'(canvas_height_q) > 32'(rrc_pkg::MAX_ROWS)) ?
                rrc_pkg::DIM_W'(rrc_pkg::MAX_ROWS) : canvas_height_q;

  assign canvas_empty = (cols == '0) || (rows == '0);
  assign in_req       = rrc_pkg::req_e'(req_type_i);
  assign in_accept    = in_valid_i && !in_stall_o;
  // Zero or negative width or height is an error
  assign size_bad     = rect_width_i[rrc_pkg::FIELD_W-1] || (rect_width_i == '0) ||
                        rect_height_i[rrc_pkg::FIELD_W-1] || (rect_height_i == '0);
  assign read_out     = (32'(pixel_x_i) >= 32'(cols)) || (32'(pixel_y_i) >= 32'(rows));

  assign last_x   = (32'(x_q) == 32'(cols) - 32'd1);
  assign last_y   = (32'(y_q) == 32'(rows) - 32'd1);
  assign out_free = !out_valid_q || !out_stall_i;

  // Scale the pixel index to fixed point for the compare unit
  assign px = rrc_pkg::coord_t'(x_q) <<< rrc_pkg::FRACTION_BITS;
  assign py = rrc_pkg::coord_t'(y_q) <<< rrc_pkg::FRACTION_BITS;

  rrc_hit u_hit (
    .px_i     (px),
    .py_i     (py),
    .bounds_i (bounds_q),
    .class_o  (pix_class)
  );

  rrc_ram #(
    .WIDTH (rrc_pkg::CHAR_W),
    .DEPTH (rrc_pkg::DEPTH)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrc_pkg::S_IDLE: begin
        if (in_accept) begin
          unique case (in_req)
            rrc_pkg::REQ_CLEAR: state_d = canvas_empty ? rrc_pkg::S_DONE : rrc_pkg::S_SWEEP;
            rrc_pkg::REQ_DRAW:  state_d = size_bad ? rrc_pkg::S_DONE : rrc_pkg::S_PREP;
            rrc_pkg::REQ_READ:  state_d = read_out ? rrc_pkg::S_DONE : rrc_pkg::S_READ;
            default:            state_d = rrc_pkg::S_DONE;
          endcase
        end
      end
      rrc_pkg::S_PREP:      state_d = rrc_pkg::S_PREP2;
      rrc_pkg::S_PREP2:     state_d = canvas_empty ? rrc_pkg::S_DONE : rrc_pkg::S_SWEEP;
      rrc_pkg::S_SWEEP:     if (last_x && last_y) state_d = rrc_pkg::S_DONE;
      rrc_pkg::S_READ:      state_d = rrc_pkg::S_READ_WAIT;
      rrc_pkg::S_READ_WAIT: state_d = rrc_pkg::S_DONE;
      rrc_pkg::S_DONE:      if (out_free) state_d = rrc_pkg::S_IDLE;
      default:              state_d = rrc_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o  = 1'b1;
    cfg_ready_o = 1'b1;
    ram_we      = 1'b0;
    ram_addr    = {y_q, x_q};
    ram_wdata   = paint_q;
    unique case (state_q)
      rrc_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
      end
      rrc_pkg::S_SWEEP: begin
        if (req_q == rrc_pkg::REQ_CLEAR) begin
          ram_we    = 1'b1;
          ram_wdata = background_char_q;
        end else begin
          ram_we = pix_class.hit && (filled_q || pix_class.border);
        end
      end
      rrc_pkg::S_READ: begin
        ram_addr = {rd_y_q, rd_x_q};
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q    <= rrc_pkg::RST_WIDTH;
      canvas_height_q   <= rrc_pkg::RST_HEIGHT;
      background_char_q <= rrc_pkg::RST_BG;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rrc_pkg::cfg_idx_e'(cfg_index_i))
        rrc_pkg::CFG_WIDTH:  canvas_width_q    <= cfg_data_i;
        rrc_pkg::CFG_HEIGHT: canvas_height_q   <= cfg_data_i;
        rrc_pkg::CFG_BG:     background_char_q <= cfg_data_i[rrc_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item and work out the rectangle bounds
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= in_req;
      filled_q <= filled_i;
      paint_q  <= paint_char_i;
      lx_q     <= rrc_pkg::coord_t'(rect_left_x_i);
      ty_q     <= rrc_pkg::coord_t'(rect_top_y_i);
      w_q      <= rrc_pkg::coord_t'(rect_width_i);
      h_q      <= rrc_pkg::coord_t'(rect_height_i);
      rd_x_q   <= rrc_pkg::COL_W'(pixel_x_i);
      rd_y_q   <= rrc_pkg::ROW_W'(pixel_y_i);
    end
    if (state_q == rrc_pkg::S_PREP) begin
      bounds_q.lx  <= lx_q;
      bounds_q.ty  <= ty_q;
      bounds_q.rx  <= lx_q + w_q;
      bounds_q.by  <= ty_q + h_q;
      bounds_q.lx1 <= lx_q + rrc_pkg::ONE;
      bounds_q.ty1 <= ty_q + rrc_pkg::ONE;
    end
    if (state_q == rrc_pkg::S_PREP2) begin
      bounds_q.rx1 <= bounds_q.rx - rrc_pkg::ONE;
      bounds_q.by1 <= bounds_q.by - rrc_pkg::ONE;
    end
  end

  // Sweep counters: advance one pixel per cycle, row by row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else if (state_q == rrc_pkg::S_SWEEP) begin
      if (last_x) begin
        x_q <= '0;
        y_q <= last_y ? '0 : y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end else if (state_q == rrc_pkg::S_IDLE) begin
      x_q <= '0;
      y_q <= '0;
    end
  end

  // Pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_status_q <= rrc_pkg::ST_OK;
      res_pix_q    <= '0;
    end else if (in_accept) begin
      res_pix_q <= '0;
      if (in_req == rrc_pkg::REQ_DRAW && size_bad) begin
        res_status_q <= rrc_pkg::ST_SIZE;
      end else if (in_req == rrc_pkg::REQ_READ && read_out) begin
        res_status_q <= rrc_pkg::ST_RANGE;
      end else begin
        res_status_q <= rrc_pkg::ST_OK;
      end
    end else if (state_q == rrc_pkg::S_READ_WAIT) begin
      res_pix_q <= ram_rdata;
    end
  end

  // Output register: load when the previous result is gone or taken in this cycle, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_pix_q    <= '0;
    end else if (state_q == rrc_pkg::S_DONE && out_free) begin
      out_valid_q  <= 1'b1;
      out_status_q <= res_status_q;
      out_pix_q    <= res_pix_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign pixel_char_o = out_pix_q;

  // An accepted item keeps the engine busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("engine took an item and was ready again at once");

  // Only a successful read carries a character
  a_char_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != rrc_pkg::ST_OK) |-> (pixel_char_o == '0))
    else $error("error result carries a character");

  // The canvas is written only by clear or draw
  a_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (req_q == rrc_pkg::REQ_CLEAR || req_q == rrc_pkg::REQ_DRAW))
    else $error("canvas written by a request that must not write");

  // The sweep stays inside the active canvas
  a_sweep_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rrc_pkg::S_SWEEP) |-> ((32'(x_q) < 32'(cols)) && (32'(y_q) < 32'(rows))))
    else $error("sweep left the active canvas");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the rectangle raster canvas: directed and random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrc_pkg::*;

  // One canvas pixel in fixed point, and the run's safety net in clock cycles.
  localparam int          UNIT        = 1 << FRACTION_BITS;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          CANVAS_SZ   = MAX_ROWS * MAX_COLUMNS;

  localparam logic [CHAR_W-1:0] CH_LOWER_R = 8'h72;  // 'r'
  localparam logic [CHAR_W-1:0] CH_UPPER_R = 8'h52;  // 'R'
  localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;  // '.'

  typedef struct {
    req_e                       kind;
    logic signed [FIELD_W-1:0]  lx;
    logic signed [FIELD_W-1:0]  ty;
    logic signed [FIELD_W-1:0]  w;
    logic signed [FIELD_W-1:0]  h;
    logic                       fill;
    logic [CHAR_W-1:0]          ch;
    logic [PIX_W-1:0]           px;
    logic [PIX_W-1:0]           py;
    bit                         wait_drain;  // hold back until the block has drained
  } canvas_req_t;

  typedef struct {
    status_e           st;
    logic [CHAR_W-1:0] ch;
  } canvas_ans_t;

  // Clock, reset and every block input start at known values.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      in_valid_i    = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                req_type_i    = '0;
  logic signed [FIELD_W-1:0] rect_left_x_i = '0;
  logic signed [FIELD_W-1:0] rect_top_y_i  = '0;
  logic signed [FIELD_W-1:0] rect_width_i  = '0;
  logic signed [FIELD_W-1:0] rect_height_i = '0;
  logic                      filled_i      = 1'b0;
  logic [CHAR_W-1:0]         paint_char_i  = '0;
  logic [PIX_W-1:0]          pixel_x_i     = '0;
  logic [PIX_W-1:0]          pixel_y_i     = '0;

  logic                      out_valid_o;
  logic                      out_stall_i   = 1'b0;
  logic [1:0]                status_o;
  logic [CHAR_W-1:0]         pixel_char_o;

  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [1:0]                cfg_index_i   = '0;
  logic [DIM_W-1:0]          cfg_data_i    = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  rectangle_raster_canvas u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .rect_left_x_i (rect_left_x_i),
    .rect_top_y_i  (rect_top_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .filled_i      (filled_i),
    .paint_char_i  (paint_char_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .pixel_char_o  (pixel_char_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Behavioral canvas: its own copy of the registers and of the pixel store.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]  cols_r = RST_WIDTH;
  logic [DIM_W-1:0]  rows_r = RST_HEIGHT;
  logic [CHAR_W-1:0] bg_r   = RST_BG;
  logic [CHAR_W-1:0] canvas_m [CANVAS_SZ];
  bit                written_m [CANVAS_SZ];  // stimulus side: pixels a clear has reached

  canvas_req_t req_q[$];     // items waiting for the driver
  canvas_ans_t answer_q[$];  // expected results, oldest first
  canvas_req_t cur_req;
  canvas_ans_t front_ans;

  int unsigned n_sent    = 0;
  int unsigned n_recv    = 0;
  int unsigned fail_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left  = 0;
  int unsigned stall_left = 0;
  bit          calm      = 1'b0;  // no gaps and no stalls while set

  // Oversized dimensions saturate to the store's size.
  function automatic int active_cols();
    return (cols_r > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_r);
  endfunction

  function automatic int active_rows();
    return (rows_r > MAX_ROWS) ? MAX_ROWS : int'(rows_r);
  endfunction

  // Apply one accepted request to the canvas and queue the result it must give.
  function automatic void canvas_apply(canvas_req_t rq);
    canvas_ans_t res;
    int          cols, rows, x, y;
    longint      lx, ty, w, h, rx, by, px, py, one;
    bit          y_edge, border;
    res.st = ST_OK;
    res.ch = '0;
    cols   = active_cols();
    rows   = active_rows();
    one    = longint'(1) << FRACTION_BITS;
    case (rq.kind)
      REQ_CLEAR: begin
        for (y = 0; y < rows; y++)
          for (x = 0; x < cols; x++)
            canvas_m[y*MAX_COLUMNS + x] = bg_r;
      end
      REQ_DRAW: begin
        lx = longint'(rq.lx);
        ty = longint'(rq.ty);
        w  = longint'(rq.w);
        h  = longint'(rq.h);
        if (w <= 0 || h <= 0) begin
          res.st = ST_SIZE;
        end else begin
          rx = lx + w;
          by = ty + h;
          for (y = 0; y < rows; y++) begin
            py = longint'(y) * one;
            if (py < ty || py > by) continue;
            // Within one unit of the top or bottom edge the whole row is border.
            y_edge = (py - ty) < one || (by - py) < one;
            for (x = 0; x < cols; x++) begin
              px = longint'(x) * one;
              if (px < lx || px > rx) continue;
              border = y_edge || (px - lx) < one || (rx - px) < one;
              if (rq.fill || border) canvas_m[y*MAX_COLUMNS + x] = rq.ch;
            end
          end
        end
      end
      REQ_READ: begin
        if (rq.px >= cols || rq.py >= rows) res.st = ST_RANGE;
        else res.ch = canvas_m[int'(rq.py)*MAX_COLUMNS + int'(rq.px)];
      end
      default: ;
    endcase
    answer_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic canvas_req_t mk_req(req_e kind, int lx, int ty, int w, int h,
                                         bit fill, logic [CHAR_W-1:0] ch,
                                         int px, int py, bit wait_drain);
    canvas_req_t rq;
    rq.kind       = kind;
    rq.lx         = FIELD_W'(lx);
    rq.ty         = FIELD_W'(ty);
    rq.w          = FIELD_W'(w);
    rq.h          = FIELD_W'(h);
    rq.fill       = fill;
    rq.ch         = ch;
    rq.px         = PIX_W'(px);
    rq.py         = PIX_W'(py);
    rq.wait_drain = wait_drain;
    return rq;
  endfunction

  // Queue an item. Never read a pixel no clear has reached: turn such a read into a clear.
  function automatic void add_req(canvas_req_t rq);
    int c, r, x, y;
    c = active_cols();
    r = active_rows();
    if (rq.kind == REQ_READ && rq.px < c && rq.py < r &&
        !written_m[int'(rq.py)*MAX_COLUMNS + int'(rq.px)])
      rq.kind = REQ_CLEAR;
    if (rq.kind == REQ_CLEAR)
      for (y = 0; y < r; y++)
        for (x = 0; x < c; x++)
          written_m[y*MAX_COLUMNS + x] = 1'b1;
    req_q.push_back(rq);
  endfunction

  // Rectangles around the canvas with random fractions, reads mostly inside it,
  // and a share of clears, size errors, raw noise and unused requests.
  function automatic canvas_req_t rand_req();
    canvas_req_t rq;
    int          c, r, cw, rh, sel;
    c  = active_cols();
    r  = active_rows();
    cw = (c == 0) ? 1 : c;
    rh = (r == 0) ? 1 : r;
    rq.kind       = REQ_DRAW;
    rq.lx         = FIELD_W'($urandom());
    rq.ty         = FIELD_W'($urandom());
    rq.w          = FIELD_W'($urandom());
    rq.h          = FIELD_W'($urandom());
    rq.fill       = 1'($urandom_range(0, 1));
    rq.ch         = CHAR_W'($urandom());
    rq.px         = PIX_W'($urandom());
    rq.py         = PIX_W'($urandom());
    rq.wait_drain = ($urandom_range(0, 11) == 0);
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      rq.kind = REQ_CLEAR;
    end else if (sel < 14) begin
      rq.kind = REQ_NONE;
    end else if (sel < 22) begin
      // keep the raw draw fields as they are
    end else if (sel < 55) begin
      rq.lx = FIELD_W'(int'($urandom_range(0, (cw + 4) * UNIT)) - 2 * UNIT);
      rq.ty = FIELD_W'(int'($urandom_range(0, (rh + 4) * UNIT)) - 2 * UNIT);
      rq.w  = FIELD_W'($urandom_range(1, (cw + 2) * UNIT));
      rq.h  = FIELD_W'($urandom_range(1, (rh + 2) * UNIT));
      if ($urandom_range(0, 3) == 0) begin
        // snap to whole pixels so edges land exactly on pixel centers
        rq.lx[FRACTION_BITS-1:0] = '0;
        rq.ty[FRACTION_BITS-1:0] = '0;
        rq.w[FRACTION_BITS-1:0]  = '0;
        rq.h[FRACTION_BITS-1:0]  = '0;
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0) rq.w = FIELD_W'(-int'($urandom_range(0, 3000)));
        else rq.h = FIELD_W'(-int'($urandom_range(0, 3000)));
      end
    end else begin
      rq.kind = REQ_READ;
      if (c > 0 && r > 0 && $urandom_range(0, 99) < 85) begin
        rq.px = PIX_W'($urandom_range(0, c - 1));
        rq.py = PIX_W'($urandom_range(0, r - 1));
      end else if (c < MAX_COLUMNS) begin
        rq.px = PIX_W'($urandom_range(c, 255));
      end else if (r < MAX_ROWS) begin
        rq.py = PIX_W'($urandom_range(r, 255));
      end
    end
    return rq;
  endfunction

  // Mostly no idling or short gaps, now and then a long one.
  function automatic int unsigned pick_idle();
    int unsigned sel;
    if (calm) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued items, hold each one while the block stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
      n_sent     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        canvas_apply(cur_req);
        n_sent <= n_sent + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (req_q.size() != 0 &&
                     !(req_q[0].wait_drain && (in_valid_i || n_sent != n_recv))) begin
          cur_req = req_q.pop_front();
          req_type_i    <= cur_req.kind;
          rect_left_x_i <= cur_req.lx;
          rect_top_y_i  <= cur_req.ty;
          rect_width_i  <= cur_req.w;
          rect_height_i <= cur_req.h;
          filled_i      <= cur_req.fill;
          paint_char_i  <= cur_req.ch;
          pixel_x_i     <= cur_req.px;
          pixel_y_i     <= cur_req.py;
          in_valid_i    <= 1'b1;
          gap_left      <= pick_idle();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      n_recv      <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_recv <= n_recv + 1;
        if (answer_q.size() == 0) begin
          $error("unexpected result item: status %0d pixel_char %0d", status_o, pixel_char_o);
          fail_cnt++;
        end else begin
          front_ans = answer_q.pop_front();
          if (status_o !== front_ans.st) begin
            $error("status: expected %0d, got %0d", front_ans.st, status_o);
            fail_cnt++;
          end
          if (pixel_char_o !== front_ans.ch) begin
            $error("pixel_char: expected %0d, got %0d", front_ans.ch, pixel_char_o);
            fail_cnt++;
          end
        end
      end
      // Stall in bursts, with a release between each burst and the next.
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= pick_idle();
      end
    end
  end

  // Safety net against a hung block.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("rectangle_raster_canvas: mismatch");
      $finish;
    end
  end

  // Write one register and mirror it into the behavioral canvas.
  task automatic cfg_write(cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= DIM_W'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_WIDTH:  cols_r = DIM_W'(val);
      CFG_HEIGHT: rows_r = DIM_W'(val);
      CFG_BG:     bg_r   = CHAR_W'(val);
      default: ;
    endcase
  endtask

  // Wait until every item is sent and answered; sample between edges to stay race free.
  task automatic wait_idle();
    do @(negedge clk_i); while (req_q.size() != 0 || in_valid_i || n_sent != n_recv);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_canvas(int unsigned cols, int unsigned rows, int unsigned bg);
    cfg_write(CFG_WIDTH, cols);
    cfg_write(CFG_HEIGHT, rows);
    cfg_write(CFG_BG, bg);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned wv, hv;
    int          sel;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full-size canvas at reset values: one clear, two draws sweeping all pixels, and two reads.
    @(negedge clk_i);
    add_req(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk_req(REQ_DRAW, -640, 100*UNIT + 64, 300*UNIT, 20*UNIT, 1, CH_UPPER_R,
                   0, 0, 0));
    add_req(mk_req(REQ_DRAW, 10*UNIT + 128, 5*UNIT, 200*UNIT + 128, 150*UNIT, 0, CH_LOWER_R,
                   0, 0, 0));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 12, 7, 0));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 255, 255, 0));

    // Small canvas: size errors, extreme corners, fractional edges, range errors.
    wait_idle();
    set_canvas(8, 6, CH_DOT);
    add_req(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk_req(REQ_DRAW, 0, 0, 0, UNIT, 1, CH_UPPER_R, 0, 0, 0));
    add_req(mk_req(REQ_DRAW, 0, 0, UNIT, -UNIT, 1, CH_UPPER_R, 0, 0, 0));
    add_req(mk_req(REQ_DRAW, -1048576, 1048575, -1048576, 1048575, 1, 8'hFF, 0, 0, 0));
    // valid size, but the right edge ends left of the canvas
    add_req(mk_req(REQ_DRAW, -1048576, -1048576, 1048575, 1048575, 1, 8'hFF, 0, 0, 0));
    add_req(mk_req(REQ_DRAW, UNIT, UNIT, 3*UNIT + 128, 2*UNIT + 192, 0, CH_LOWER_R,
                   0, 0, 0));
    // half-pixel wide column, all border
    add_req(mk_req(REQ_DRAW, 2*UNIT, 0, 128, 5*UNIT, 1, 8'h00, 0, 0, 0));
    add_req(mk_req(REQ_DRAW, 4*UNIT + 1, -100, 3*UNIT, 3*UNIT, 1, CH_UPPER_R, 0, 0, 0));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 1, 1, 0));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 2, 2, 1));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 5, 2, 0));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 7, 5, 0));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 8, 0, 0));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 6, 0));
    add_req(mk_req(REQ_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // Empty canvas: zero width, height above the maximum.
    wait_idle();
    set_canvas(0, 300, 8'h00);
    add_req(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // Width above the maximum saturates: one full row.
    wait_idle();
    set_canvas(511, 1, 8'hFF);
    add_req(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 255, 0, 0));

    // Random phases, each on a fresh setting and starting from a clear.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      sel = $urandom_range(0, 9);
      if (p == 0) begin
        wv = 1;
        hv = 1;
      end else if (sel == 0) begin
        wv = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 8);
        hv = (wv == 0) ? $urandom_range(1, 8) : 0;
      end else if (sel == 1) begin
        wv = $urandom_range(257, 511);
        hv = $urandom_range(1, 3);
      end else if (sel == 2) begin
        wv = $urandom_range(1, 3);
        hv = $urandom_range(257, 511);
      end else if (sel < 5) begin
        wv = $urandom_range(13, 40);
        hv = $urandom_range(1, 20);
      end else begin
        wv = $urandom_range(1, 12);
        hv = $urandom_range(1, 12);
      end
      set_canvas(wv, hv, $urandom_range(0, 255));
      calm = (p % 3 == 1);
      add_req(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      repeat (12) add_req(rand_req());
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && answer_q.size() == 0) begin
      $display("rectangle_raster_canvas: match");
    end else begin
      $display("rectangle_raster_canvas: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rrc_pkg.sv
sv/rrc_ram.sv
sv/rrc_hit.sv
sv/rectangle_raster_canvas.sv
tb/tb.sv
